// ===== rtl/rhp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_pkg: shared types and constants for the RTP header parser
// Packet summary handed from the byte parser to the evaluator, result item
// layout, and the fixed header constants.
// ----------------------------------------------------------------------------
package rhp_pkg;

  // Fixed header length in bytes and extension header size
  localparam logic [6:0] HDR_FIXED     = 7'd12;
  localparam logic [6:0] EXT_HDR_BYTES = 7'd4;
  localparam logic [1:0] RTP_VERSION   = 2'd2;

  // Everything the evaluator needs about one finished packet
  typedef struct packed {
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [15:0] len;
    logic [18:0] hdr_end;
    logic [7:0]  pad_cnt;
  } summary_t;

  // One result item
  typedef struct packed {
    logic        ok;
    logic        padding;
    logic        extension;
    logic [3:0]  contrib_cnt;
    logic        marker;
    logic [6:0]  pt_code;
    logic [15:0] seq_num;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [15:0] payload_offset;
    logic [15:0] payload_size;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/rtp_header_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_header_parser: RTP fixed header parser
// Byte-serial RTP packet parser with queue handshakes on both sides.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while full is low, with last_byte on the final
// byte, and delivers one result item per packet. The byte counter and field
// capture run at one byte per clock while full is low, with no gaps between
// packets. A two-entry summary queue sits between capture and evaluation and
// a two-entry result queue drives the outputs; a packet's result passes through
// both before it is visible. Full only rises when both queues are backed up by
// a stalled pop. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module rtp_header_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             ok,
  output logic             padding,
  output logic             extension,
  output logic [3:0]       contrib_cnt,
  output logic             marker,
  output logic [6:0]       pt_code,
  output logic [15:0]      seq_num,
  output logic [31:0]      timestamp,
  output logic [31:0]      ssrc,
  output logic [15:0]      payload_offset,
  output logic [15:0]      payload_size
);
  import rhp_pkg::*;

  localparam int unsigned SumW = $bits(summary_t);
  localparam int unsigned ResW = $bits(result_t);

  logic     accept;
  logic     mid_push, mid_full, mid_empty, mid_pop;
  logic     out_push, out_full, out_empty;
  summary_t sum_in, sum_head;
  result_t  res_in, res_head;

  assign full     = mid_full;
  assign accept   = push && !mid_full;
  assign mid_push = accept && last_byte;

  // Byte capture
  rhp_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .summary   (sum_in)
  );

  // Summary queue
  rhp_fifo #(.WIDTH(SumW), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (sum_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (sum_head),
    .empty (mid_empty)
  );

  // Evaluation
  rhp_back u_back (
    .summary (sum_head),
    .result  (res_in)
  );

  assign mid_pop  = !mid_empty && !out_full;
  assign out_push = mid_pop;

  // Result queue
  rhp_fifo #(.WIDTH(ResW), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (res_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign empty          = out_empty;
  assign ok             = res_head.ok;
  assign padding        = res_head.padding;
  assign extension      = res_head.extension;
  assign contrib_cnt    = res_head.contrib_cnt;
  assign marker         = res_head.marker;
  assign pt_code        = res_head.pt_code;
  assign seq_num        = res_head.seq_num;
  assign timestamp      = res_head.timestamp;
  assign ssrc           = res_head.ssrc;
  assign payload_offset = res_head.payload_offset;
  assign payload_size   = res_head.payload_size;

  // Checks
  a_last_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_byte) |=> !mid_empty)
    else $error("last byte taken but no summary queued");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result queue written while full");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !ok) |-> (payload_size == 16'd0 && payload_offset == 16'd0
                         && ssrc == 32'd0 && seq_num == 16'd0))
    else $error("malformed packet result carries nonzero fields");

  a_good_offset: assert property (@(posedge clk) disable iff (rst)
    (!empty && ok) |-> (payload_offset >= 16'(HDR_FIXED)))
    else $error("valid packet with header shorter than fixed part");

endmodule
`default_nettype wire

// ===== rtl/rhp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_fifo: small register queue
// Decouples the parser stages; full and empty come straight from the count
// register.
// ----------------------------------------------------------------------------
module rhp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rhp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_front: byte-level header capture
// Counts bytes, steers each byte into its header field, tracks the header
// length through the CSRC list and extension, and forms the packet summary
// on the last byte.
// ----------------------------------------------------------------------------
module rhp_front #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output rhp_pkg::summary_t summary
);
  import rhp_pkg::*;

  localparam logic [15:0] MaxBytes = 16'(MAX_PACKET_BYTES);

  logic [15:0] byte_index, byte_index_next;
  logic [7:0]  hdr0, hdr0_next;
  logic [7:0]  hdr1, hdr1_next;
  logic [15:0] seq_reg, seq_reg_next;
  logic [31:0] time_reg, time_reg_next;
  logic [31:0] source_reg, source_reg_next;
  logic [7:0]  ext_high, ext_high_next;
  logic [18:0] header_end, header_end_next;
  logic        sat;
  logic [6:0]  base;
  logic [15:0] len;

  // Byte classification and field capture
  always_comb begin
    sat             = (byte_index >= MaxBytes);
    base            = HDR_FIXED + {1'b0, hdr0[3:0], 2'b00};
    byte_index_next = byte_index;
    hdr0_next       = hdr0;
    hdr1_next       = hdr1;
    seq_reg_next    = seq_reg;
    time_reg_next   = time_reg;
    source_reg_next = source_reg;
    ext_high_next   = ext_high;
    header_end_next = header_end;
    if (!sat) begin
      if (byte_index == 16'd0) begin
        hdr0_next       = data_byte;
        header_end_next = 19'(HDR_FIXED) + {13'b0, data_byte[3:0], 2'b00};
      end else if (byte_index == 16'd1) begin
        hdr1_next = data_byte;
      end else if (byte_index < 16'd4) begin
        seq_reg_next = {seq_reg[7:0], data_byte};
      end else if (byte_index < 16'd8) begin
        time_reg_next = {time_reg[23:0], data_byte};
      end else if (byte_index < 16'(HDR_FIXED)) begin
        source_reg_next = {source_reg[23:0], data_byte};
      end else if (byte_index == 16'(base) + 16'd2) begin
        ext_high_next = data_byte;
      end else if (byte_index == 16'(base) + 16'd3) begin
        // extension word count complete
        if (hdr0[4]) begin
          header_end_next = 19'(base) + 19'(EXT_HDR_BYTES)
                            + {1'b0, ext_high, data_byte, 2'b00};
        end
      end
      byte_index_next = byte_index + 16'd1;
    end
    len = sat ? MaxBytes : byte_index + 16'd1;
  end

  // Summary of the packet as of this byte
  always_comb begin
    summary.hdr0    = hdr0_next;
    summary.hdr1    = hdr1_next;
    summary.seq     = seq_reg_next;
    summary.ts      = time_reg_next;
    summary.ssrc    = source_reg_next;
    summary.len     = len;
    summary.hdr_end = header_end_next;
    summary.pad_cnt = data_byte;
  end

  // Per-packet state; counters rearm after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      hdr0       <= '0;
      hdr1       <= '0;
      seq_reg    <= '0;
      time_reg   <= '0;
      source_reg <= '0;
      ext_high   <= '0;
      header_end <= 19'(HDR_FIXED);
    end else if (accept) begin
      hdr0       <= hdr0_next;
      hdr1       <= hdr1_next;
      seq_reg    <= seq_reg_next;
      time_reg   <= time_reg_next;
      source_reg <= source_reg_next;
      if (last_byte) begin
        byte_index <= '0;
        ext_high   <= '0;
        header_end <= 19'(HDR_FIXED);
      end else begin
        byte_index <= byte_index_next;
        ext_high   <= ext_high_next;
        header_end <= header_end_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rhp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_back: packet evaluation
// Validates a finished packet summary and works out the payload offset and
// the payload length net of padding.
// ----------------------------------------------------------------------------
module rhp_back (
  input  rhp_pkg::summary_t summary,
  output rhp_pkg::result_t  result
);
  import rhp_pkg::*;

  logic [6:0]  base;
  logic        ok;
  logic [15:0] plen_raw;
  logic [16:0] plen_pad;
  logic [15:0] plen;

  always_comb begin
    base = HDR_FIXED + {1'b0, summary.hdr0[3:0], 2'b00};

    // Validity: long enough, version 2, header fully present
    ok = (summary.len >= 16'(HDR_FIXED))
         && (summary.hdr0[7:6] == RTP_VERSION)
         && (summary.len >= 16'(base))
         && (!summary.hdr0[4]
             || ((17'(base) + 17'(EXT_HDR_BYTES) <= {1'b0, summary.len})
                 && ({3'b0, summary.len} >= summary.hdr_end)));

    // Payload length, padding count off, clamped at zero
    plen_raw = summary.len - summary.hdr_end[15:0];
    plen_pad = {1'b0, plen_raw} - {9'b0, summary.pad_cnt};
    if (summary.hdr0[5] && (plen_raw != 16'd0)) begin
      plen = plen_pad[16] ? 16'd0 : plen_pad[15:0];
    end else begin
      plen = plen_raw;
    end

    result = '0;
    if (ok) begin
      result.ok             = 1'b1;
      result.padding        = summary.hdr0[5];
      result.extension      = summary.hdr0[4];
      result.contrib_cnt    = summary.hdr0[3:0];
      result.marker         = summary.hdr1[7];
      result.pt_code        = summary.hdr1[6:0];
      result.seq_num        = summary.seq;
      result.timestamp      = summary.ts;
      result.ssrc           = summary.ssrc;
      result.payload_offset = summary.hdr_end[15:0];
      result.payload_size   = plen;
    end
  end

endmodule
`default_nettype wire

// ===== bench/rtp_header_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_header_parser_test: self-checking bench for the RTP header parser
// Streams RTP packets one byte per item into the push/full side: corner-case
// packets first, then random valid, truncated, bad-version and junk packets.
// A scoreboard tracks the parser state, predicts one result item per packet
// and checks every item popped from the output side, under random stalls on
// both sides and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module rtp_header_parser_test;
  import rhp_pkg::*;

  localparam int unsigned MAX_PKT      = 65535;
  localparam int unsigned FIXED_BYTES  = 32'(HDR_FIXED);
  localparam int unsigned EXT_BYTES    = 32'(EXT_HDR_BYTES);
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_BYTES = 460;   // per idling mix
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam longint      TIMEOUT_NS   = 64'd12_000_000;

  // Scoreboard: mirrors the parser state and holds the predicted result items
  class rtp_result_board;
    int unsigned byte_count;
    int unsigned hdr_len;
    logic [7:0]  hdr0, hdr1, ext_hi;
    logic [15:0] seq_word, ext_cnt;
    logic [31:0] ts_word, src_word;
    result_t     want_q[$];
    int unsigned errors, packets, good_packets, longest;

    function new();
      hdr0 = '0;
      hdr1 = '0;
      seq_word = '0;
      ts_word = '0;
      src_word = '0;
      errors = 0;
      packets = 0;
      good_packets = 0;
      longest = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_count = 0;
      ext_hi = '0;
      ext_cnt = '0;
      hdr_len = FIXED_BYTES;
    endfunction

    // Advance by one accepted byte; predict the result item on the last one
    function void note_byte(logic [7:0] b, logic last);
      int unsigned pos, pkt_len, base, plen;
      bit          good;
      result_t     want;
      pos = byte_count;
      if (pos < MAX_PKT) begin
        base = FIXED_BYTES + 4 * hdr0[3:0];
        if (pos == 0) begin
          hdr0 = b;
          hdr_len = FIXED_BYTES + 4 * b[3:0];
        end else if (pos == 1) begin
          hdr1 = b;
        end else if (pos < 4) begin
          seq_word = {seq_word[7:0], b};
        end else if (pos < 8) begin
          ts_word = {ts_word[23:0], b};
        end else if (pos < FIXED_BYTES) begin
          src_word = {src_word[23:0], b};
        end else if (pos == base + 2) begin
          ext_hi = b;
        end else if (pos == base + 3) begin
          ext_cnt = {ext_hi, b};
          // header end only moves when the extension bit is set
          if (hdr0[4]) hdr_len = (base + EXT_BYTES + ext_cnt * 4) & 32'h7FFFF;
        end
        byte_count = pos + 1;
        pkt_len = pos + 1;
      end else begin
        byte_count = MAX_PKT;
        pkt_len = MAX_PKT;
      end
      if (!last) return;

      // end of packet: validate and build the result
      base = FIXED_BYTES + 4 * hdr0[3:0];
      good = 1'b1;
      if (pkt_len < FIXED_BYTES) good = 1'b0;
      else if (hdr0[7:6] != RTP_VERSION) good = 1'b0;
      else if (pkt_len < base) good = 1'b0;
      else if (hdr0[4] && (base + EXT_BYTES > pkt_len || pkt_len < hdr_len)) good = 1'b0;

      want = '0;
      if (good) begin
        plen = pkt_len - hdr_len;
        // padding count from the last byte, clamped at zero
        if (hdr0[5] && plen > 0) plen = (b < plen) ? plen - b : 0;
        want.ok = 1'b1;
        want.padding = hdr0[5];
        want.extension = hdr0[4];
        want.contrib_cnt = hdr0[3:0];
        want.marker = hdr1[7];
        want.pt_code = hdr1[6:0];
        want.seq_num = seq_word;
        want.timestamp = ts_word;
        want.ssrc = src_word;
        want.payload_offset = hdr_len[15:0];
        want.payload_size = plen[15:0];
        good_packets++;
      end
      want_q.push_back(want);
      packets++;
      if (pkt_len > longest) longest = pkt_len;
      clear_packet();
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare a popped result item with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        return;
      end
      want = want_q.pop_front();
      match_field("ok", want.ok, got.ok);
      match_field("padding", want.padding, got.padding);
      match_field("extension", want.extension, got.extension);
      match_field("contrib_cnt", want.contrib_cnt, got.contrib_cnt);
      match_field("marker", want.marker, got.marker);
      match_field("pt_code", want.pt_code, got.pt_code);
      match_field("seq_num", want.seq_num, got.seq_num);
      match_field("timestamp", want.timestamp, got.timestamp);
      match_field("ssrc", want.ssrc, got.ssrc);
      match_field("payload_offset", want.payload_offset, got.payload_offset);
      match_field("payload_size", want.payload_size, got.payload_size);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic        ok, padding, extension, marker;
  logic [3:0]  contrib_cnt;
  logic [6:0]  pt_code;
  logic [15:0] seq_num, payload_offset, payload_size;
  logic [31:0] timestamp, ssrc;

  rtp_result_board board = new();
  logic [7:0]      pkt[$];
  int unsigned     send_idle_pct = 13;
  int unsigned     recv_idle_pct = 52;
  int unsigned     bytes_sent = 0;
  int unsigned     stall_cycles = 0;
  bit              hold_request = 1'b0;

  rtp_header_parser #(.MAX_PACKET_BYTES(MAX_PKT)) u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop),
    .ok(ok), .padding(padding), .extension(extension), .contrib_cnt(contrib_cnt),
    .marker(marker), .pt_code(pt_code), .seq_num(seq_num),
    .timestamp(timestamp), .ssrc(ssrc), .payload_offset(payload_offset),
    .payload_size(payload_size)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one byte, with random idle cycles first; returns once it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (full) begin
      stall_cycles++;
      @(posedge clk);
    end
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Build a packet: fixed header, CSRC list, optional extension, payload
  task automatic build_packet(input logic [1:0] ver, input bit pad_bit, input bit ext_bit,
                              input logic [3:0] cc, input int unsigned ext_words,
                              input int unsigned payload_n, input logic [7:0] pad_val);
    pkt.delete();
    pkt.push_back({ver, pad_bit, ext_bit, cc});
    repeat (FIXED_BYTES - 1) pkt.push_back(8'($urandom));
    repeat (4 * cc) pkt.push_back(8'($urandom));
    if (ext_bit) begin
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back(ext_words[15:8]);
      pkt.push_back(ext_words[7:0]);
      repeat (4 * ext_words) pkt.push_back(8'($urandom));
    end
    repeat (payload_n) pkt.push_back(8'($urandom));
    if (pad_bit && payload_n > 0) pkt[pkt.size() - 1] = pad_val;
  endtask

  task automatic truncate(input int unsigned n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  task automatic fill_fixed(input logic [7:0] b);
    for (int i = 1; i < FIXED_BYTES; i++) pkt[i] = b;
  endtask

  // Mostly well-formed packets with random content, plus broken ones and junk
  task automatic random_packet();
    int unsigned kind, cc, plen, n;
    logic [1:0]  ver;
    bit          p, x;
    kind = $urandom_range(99);
    p = ($urandom_range(2) == 0);
    x = ($urandom_range(2) == 0);
    cc = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(15);
    plen = $urandom_range(24);
    ver = RTP_VERSION;
    if (kind >= 72 && kind < 84) begin
      ver = 2'($urandom_range(3));
      if (ver == RTP_VERSION) ver = 2'($urandom_range(1));
    end
    if (kind < 84) begin
      build_packet(ver, p, x, cc[3:0], $urandom_range(3), plen,
                   ($urandom_range(1) == 0) ? 8'($urandom_range(plen)) : 8'($urandom));
      if (kind >= 60 && kind < 72) truncate($urandom_range(1, pkt.size() - 1));
    end else begin
      pkt.delete();
      n = $urandom_range(1, 20);
      repeat (n) pkt.push_back(8'($urandom));
    end
    send_packet();
  endtask

  // Output side: check popped items, random pops, one long hold-off on request
  initial begin
    int unsigned hold_left;
    result_t     got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = {ok, padding, extension, contrib_cnt, marker, pt_code, seq_num,
               timestamp, ssrc, payload_offset, payload_size};
        board.check_result(got);
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned mark;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // minimal header, all-ones and all-zero fields
    build_packet(RTP_VERSION, 0, 0, 0, 0, 0, 0);
    send_packet();
    build_packet(RTP_VERSION, 0, 0, 0, 0, 6, 0);
    fill_fixed(8'hFF);
    send_packet();
    build_packet(RTP_VERSION, 0, 0, 0, 0, 3, 0);
    fill_fixed(8'h00);
    send_packet();
    // full CSRC list, extension with zero and nonzero word counts
    build_packet(RTP_VERSION, 0, 0, 15, 0, 5, 0);
    send_packet();
    build_packet(RTP_VERSION, 0, 1, 0, 0, 4, 0);
    send_packet();
    build_packet(RTP_VERSION, 1, 1, 3, 2, 10, 3);
    send_packet();
    // padding below, equal to and above the payload length, and no payload
    build_packet(RTP_VERSION, 1, 0, 0, 0, 8, 3);
    send_packet();
    build_packet(RTP_VERSION, 1, 0, 0, 0, 8, 8);
    send_packet();
    build_packet(RTP_VERSION, 1, 0, 0, 0, 8, 255);
    send_packet();
    build_packet(RTP_VERSION, 1, 0, 0, 0, 0, 0);
    send_packet();
    // packet ends right at the end of the extension
    build_packet(RTP_VERSION, 0, 1, 1, 1, 0, 0);
    send_packet();
    // too short: single byte, eleven bytes, shorter than the CSRC list
    build_packet(RTP_VERSION, 0, 0, 0, 0, 4, 0);
    truncate(1);
    send_packet();
    build_packet(RTP_VERSION, 0, 0, 0, 0, 4, 0);
    truncate(FIXED_BYTES - 1);
    send_packet();
    build_packet(RTP_VERSION, 0, 0, 1, 0, 0, 0);
    truncate(FIXED_BYTES);
    send_packet();
    // every other version
    for (int v = 0; v < 4; v++) begin
      if (v != RTP_VERSION) begin
        build_packet(2'(v), 0, 0, 0, 0, 4, 0);
        send_packet();
      end
    end
    // truncated in the CSRC list, extension header and extension data
    build_packet(RTP_VERSION, 0, 0, 4, 0, 0, 0);
    truncate(20);
    send_packet();
    build_packet(RTP_VERSION, 0, 1, 0, 0, 0, 0);
    truncate(14);
    send_packet();
    build_packet(RTP_VERSION, 0, 1, 0, 3, 0, 0);
    truncate(20);
    send_packet();
    // largest extension word count, far past the packet end
    build_packet(RTP_VERSION, 0, 1, 0, 0, 8, 0);
    pkt[14] = 8'hFF;
    pkt[15] = 8'hFF;
    send_packet();

    // random traffic under three idling mixes
    mark = bytes_sent;
    while (bytes_sent < mark + RANDOM_BYTES) random_packet();
    send_idle_pct = 52;
    recv_idle_pct = 13;
    mark = bytes_sent;
    while (bytes_sent < mark + RANDOM_BYTES) random_packet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    mark = bytes_sent;
    while (bytes_sent < mark + RANDOM_BYTES) random_packet();
    push <= 1'b0;

    // drain, then watch for stray items
    while (board.want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d packets in %0d bytes: %0d valid, %0d rejected, longest %0d bytes.",
             board.packets, bytes_sent, board.good_packets,
             board.packets - board.good_packets, board.longest);
    $display("Input held off by full for %0d cycles across three stall mixes.", stall_cycles);
    if (board.errors == 0) begin
      $display("rtp_header_parser regression: pass");
    end else begin
      $display("rtp_header_parser regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d result items outstanding.", board.want_q.size());
    $display("rtp_header_parser regression: fail");
    $finish;
  end

endmodule
